// File: src/swmf_pkg.sv
// Shared constants for the sliding window maximum filter.
`default_nettype none

package swmf_pkg;

    // Width of the window length register on the configuration port.
    localparam int CFG_W = 7;

endpackage : swmf_pkg

`default_nettype wire

// File: src/swmf_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
`default_nettype none

module swmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    output logic      [WIDTH-1:0]                       o_rd_data_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]                       o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule : swmf_ram

`default_nettype wire

// File: src/sliding_window_max_filter.sv
// Top level of the sliding window maximum filter.
//
//  channel   | direction | handshake                          | payload
//  ----------+-----------+------------------------------------+---------------------------
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready  | tdata: sample, tuser: restart
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready  | tdata: window_max
//  cfg       | in        | i_cfg_valid / o_cfg_ready          | window_size
//
// One sample is taken per cycle. Level j of a power-of-two max table (max of the
// 2^j samples ending at each position) lives in its own RAM and is built in its
// own pipeline stage from the level below. The output queue holds LEVELS + 2
// results; the input stalls only when that many results are pending.
// Reset is synchronous; the RAMs need no clearing pass after reset.
`default_nettype none

module sliding_window_max_filter
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // s_axis tdata: [SAMPLE_WIDTH-1:0] sample, rest zero padding
    input  wire logic                                    i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,
    // s_axis tuser: [0] restart
    input  wire logic                                    i_s_axis_tuser,
    // m_axis tdata: [SAMPLE_WIDTH-1:0] window_max, rest zero padding
    output logic                                         o_m_axis_tvalid,
    input  wire logic                                    i_m_axis_tready,
    output logic      [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] o_m_axis_tdata,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [CFG_W-1:0]                        i_cfg_data
);

    localparam int TDW    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SW     = SAMPLE_WIDTH;
    localparam int PW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW     = PW + 1;
    localparam int FW     = $clog2(MAX_WINDOW + 1) > 0 ? $clog2(MAX_WINDOW + 1) : 1;
    localparam int CW     = (FW > CFG_W) ? FW : CFG_W;
    localparam int LEVELS = ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0) + 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int FD     = LEVELS + 2;
    localparam int FPW    = $clog2(FD);
    localparam int PCW    = $clog2(FD + 1);

    function automatic logic [SW-1:0] smax(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    // Circular address p - d, with d below MAX_WINDOW.
    function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] p, input logic [AW-1:0] d);
        logic [AW-1:0] pe;
        logic [AW-1:0] res;
        pe  = {1'b0, p};
        res = (pe >= d) ? (pe - d) : (pe + AW'(MAX_WINDOW) - d);
        return res[PW-1:0];
    endfunction

    // Configuration: effective window length, its level and the query offset.
    logic [FW-1:0] r_k, n_k;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [FW-1:0] r_off, n_off;
    logic [CW-1:0] cfg_ext;
    logic          cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign cfg_ext     = CW'(i_cfg_data);

    always_comb begin
        if (cfg_ext == '0) begin
            n_k = FW'(1);
        end else if (cfg_ext > CW'(MAX_WINDOW)) begin
            n_k = FW'(MAX_WINDOW);
        end else begin
            n_k = cfg_ext[FW-1:0];
        end
        n_lvl = '0;
        for (int i = 0; i < FW; i++) begin
            if (n_k[i]) begin
                n_lvl = LW'(i);
            end
        end
        n_off = n_k - (FW'(1) << n_lvl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= FW'(1);
            r_lvl <= '0;
            r_off <= '0;
        end else if (cfg_acc) begin
            r_k   <= n_k;
            r_lvl <= n_lvl;
            r_off <= n_off;
        end
    end

    // Input side: fill count and write pointer.
    logic          in_acc;
    logic [SW-1:0] in_sample;
    logic [FW-1:0] r_fill, n_fill, fill_base;
    logic [PW-1:0] r_wptr, n_wptr;
    logic          in_emit;
    logic [PCW-1:0] r_pend;

    assign o_s_axis_tready = (r_pend < PCW'(FD));
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign in_sample       = i_s_axis_tdata[SW-1:0];

    always_comb begin
        fill_base = i_s_axis_tuser ? '0 : r_fill;
        n_fill    = (fill_base < FW'(MAX_WINDOW)) ? fill_base + FW'(1) : fill_base;
        n_wptr    = (r_wptr == PW'(MAX_WINDOW - 1)) ? '0 : r_wptr + PW'(1);
        in_emit   = (n_fill >= r_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wptr <= '0;
        end else if (in_acc) begin
            r_fill <= n_fill;
            r_wptr <= n_wptr;
        end
    end

    // Level pipeline: stage j holds max of 2^j samples ending at its position.
    logic          r_vld  [LEVELS];
    logic          r_emit [LEVELS];
    logic [PW-1:0] r_ptr  [LEVELS];
    logic [SW-1:0] r_max  [LEVELS];
    logic [SW-1:0] r_sel  [LEVELS];
    logic [SW-1:0] n_max  [LEVELS];
    logic [SW-1:0] n_sel  [LEVELS];
    logic [SW-1:0] rdb    [LEVELS];
    logic [SW-1:0] rdq    [LEVELS];
    logic          wr_en  [LEVELS];
    logic [PW-1:0] wr_ptr [LEVELS];
    logic [PW-1:0] q_base;
    logic [PW-1:0] q_addr;

    // The query reads at the position of the item entering the last stage.
    if (LEVELS > 1) begin : g_qbase_deep
        assign q_base = r_ptr[LEVELS-2];
    end else begin : g_qbase_flat
        assign q_base = r_wptr;
    end
    assign q_addr = ring_sub(q_base, AW'(r_off));

    for (genvar j = 0; j < LEVELS; j++) begin : g_lvl
        logic [PW-1:0] rd_a;

        if (j == 0) begin : g_first
            assign wr_en[j]  = in_acc;
            assign wr_ptr[j] = r_wptr;
            assign n_max[j]  = in_sample;
            assign n_sel[j]  = in_sample;
        end else begin : g_next
            assign wr_en[j]  = r_vld[j-1];
            assign wr_ptr[j] = r_ptr[j-1];
            assign n_max[j]  = smax(r_max[j-1], rdb[j-1]);
            assign n_sel[j]  = (r_lvl == LW'(j)) ? n_max[j] : r_sel[j-1];
        end

        if (j < LEVELS - 1) begin : g_build
            assign rd_a = ring_sub(wr_ptr[j], AW'(2 ** j));
        end else begin : g_nobuild
            assign rd_a = q_addr;
        end

        swmf_ram #(
            .WIDTH (SW),
            .DEPTH (MAX_WINDOW)
        ) u_lvl_ram (
            .i_clk       (i_clk),
            .i_wr_en     (wr_en[j]),
            .i_wr_addr   (wr_ptr[j]),
            .i_wr_data   (n_max[j]),
            .i_rd_addr_a (rd_a),
            .o_rd_data_a (rdb[j]),
            .i_rd_addr_b (q_addr),
            .o_rd_data_b (rdq[j])
        );

        always_ff @(posedge i_clk) begin
            r_ptr[j] <= wr_ptr[j];
            r_max[j] <= n_max[j];
            r_sel[j] <= n_sel[j];
        end

        if (j == 0) begin : g_ctl_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j]  <= 1'b0;
                    r_emit[j] <= 1'b0;
                end else begin
                    r_vld[j]  <= in_acc;
                    r_emit[j] <= in_acc & in_emit;
                end
            end
        end else begin : g_ctl_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j]  <= 1'b0;
                    r_emit[j] <= 1'b0;
                end else begin
                    r_vld[j]  <= r_vld[j-1];
                    r_emit[j] <= r_emit[j-1];
                end
            end
        end
    end

    // Final combine and output queue.
    logic          push;
    logic          pop;
    logic [SW-1:0] result;
    logic [SW-1:0] r_fifo [FD];
    logic [FPW-1:0] r_head, r_tail;
    logic [PCW-1:0] r_cnt;

    assign push   = r_vld[LEVELS-1] & r_emit[LEVELS-1];
    assign result = (r_off == '0) ? r_sel[LEVELS-1] : smax(r_sel[LEVELS-1], rdq[r_lvl]);
    assign pop    = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_tail] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (push) begin
                r_tail <= (r_tail == FPW'(FD - 1)) ? '0 : r_tail + FPW'(1);
            end
            if (pop) begin
                r_head <= (r_head == FPW'(FD - 1)) ? '0 : r_head + FPW'(1);
            end
            r_cnt  <= r_cnt + PCW'(push) - PCW'(pop);
            r_pend <= r_pend + PCW'(in_acc & in_emit) - PCW'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);

    if (TDW > SW) begin : g_pad
        assign o_m_axis_tdata = {{(TDW - SW){1'b0}}, r_fifo[r_head]};
    end else begin : g_nopad
        assign o_m_axis_tdata = r_fifo[r_head];
    end

    // Results in the queue never outnumber those counted as pending.
    a_pend_covers_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pend)
        else $error("output queue holds more results than are pending");

    // A push never lands on a full queue unless a result leaves at the same edge.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < PCW'(FD)) || pop)
        else $error("output queue overflow");

    // A restart request makes its sample the first of the new sequence.
    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser) |=> (r_fill == FW'(1)))
        else $error("fill count not reset by restart");

    // A request that will give a result, while no result leaves, raises the pending count by one.
    a_pend_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_emit && !pop) |=> (r_pend == $past(r_pend) + PCW'(1)))
        else $error("pending count did not grow");

    // Every result pushed was counted when its request was taken.
    a_push_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_pend != '0))
        else $error("result pushed with nothing pending");

endmodule : sliding_window_max_filter

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the sliding window maximum filter.
`timescale 1ns / 100ps

module tb
    import swmf_pkg::*;
();

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    restart;
    } t_sample_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic              o_cfg_ready;

    t_sample_req               pending_samples[$];
    logic signed [SAMPLE_WIDTH-1:0] expected_max[$];
    t_idle_mode                idle_mode = IDLE_NONE;
    int                        error_count = 0;
    int                        cycle_count = 0;

    // Predicted state of the filter.
    logic signed [SAMPLE_WIDTH-1:0] history[MAX_WINDOW];
    int unsigned                    held_count;
    int unsigned                    next_slot;
    logic [CFG_W-1:0]               window_reg;

    sliding_window_max_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stores the sample and returns whether the sequence holds a full window,
    // with the window maximum in peak.
    function automatic bit advance_window(input logic signed [SAMPLE_WIDTH-1:0] s,
                                          input logic restart,
                                          output logic signed [SAMPLE_WIDTH-1:0] peak);
        int unsigned k;
        int unsigned slot;
        if (restart)
            held_count = 0;
        history[next_slot] = s;
        slot = next_slot;
        next_slot = (next_slot + 1) % MAX_WINDOW;
        if (held_count < MAX_WINDOW)
            held_count++;
        if (window_reg == 0)
            k = 1;
        else if (window_reg > MAX_WINDOW)
            k = MAX_WINDOW;
        else
            k = 32'(window_reg);
        peak = s;
        if (held_count < k)
            return 1'b0;
        for (int i = 1; i < k; i++) begin
            slot = (slot == 0) ? MAX_WINDOW - 1 : slot - 1;
            if (history[slot] > peak)
                peak = history[slot];
        end
        return 1'b1;
    endfunction

    // Driver: presents queued samples and paces the result side.
    always @(posedge i_clk) begin
        bit src_gap;
        bit sink_stall;
        src_gap = (idle_mode == IDLE_SRC && $urandom_range(0, 99) < 49)
               || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14);
        sink_stall = (idle_mode == IDLE_SINK && $urandom_range(0, 99) < 49)
                  || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14);
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready)
                void'(pending_samples.pop_front());
            // A request that has not been taken yet must be held as it is.
            if (!s_tvalid || o_s_axis_tready) begin
                if (pending_samples.size() != 0 && !src_gap) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DATA_W'(pending_samples[0].sample);
                    s_tuser  <= pending_samples[0].restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !sink_stall;
        end
    end

    // Monitor: predicts on every accepted request and checks every result.
    always @(posedge i_clk) begin
        logic signed [SAMPLE_WIDTH-1:0] peak;
        logic signed [SAMPLE_WIDTH-1:0] want;
        logic signed [SAMPLE_WIDTH-1:0] got;
        if (!i_rst_n) begin
            held_count = 0;
            next_slot = 0;
            window_reg = CFG_W'(1);
        end else begin
            if (cfg_valid && o_cfg_ready)
                window_reg = cfg_data;
            if (s_tvalid && o_s_axis_tready) begin
                if (advance_window(s_tdata[SAMPLE_WIDTH-1:0], s_tuser, peak))
                    expected_max.insert(expected_max.size(), peak);
            end
            if (o_m_axis_tvalid && m_tready) begin
                got = o_m_axis_tdata[SAMPLE_WIDTH-1:0];
                if (expected_max.size() == 0) begin
                    $error("window_max: no result expected, actual %0d", got);
                    error_count++;
                end else begin
                    want = expected_max.pop_front();
                    if (got !== want) begin
                        $error("window_max mismatch: expected %0d, actual %0d", want, got);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic queue_sample(input logic [SAMPLE_WIDTH-1:0] s, input logic restart);
        t_sample_req req;
        req.sample = s;
        req.restart = restart;
        pending_samples.insert(pending_samples.size(), req);
    endtask

    // Waits until every request is taken and every result has come, then lets
    // the pipeline settle, since the last requests may have had no result.
    task automatic drain();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_max.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        drain();
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 7)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // Mostly full sequences with random content, some cut short, and a few
    // stray restarts. The first sequence may carry on from the previous phase
    // so that a new window length meets a running sequence.
    task automatic random_phase(input t_idle_mode how, input logic [CFG_W-1:0] wsize,
                                input int count);
        int  k;
        int  len;
        int  pushed;
        bit  first;
        bit  flag;
        write_window(wsize);
        idle_mode = how;
        k = (wsize == 0) ? 1 : ((wsize > MAX_WINDOW) ? MAX_WINDOW : int'(wsize));
        pushed = 0;
        first = 1'b1;
        while (pushed < count) begin
            if ($urandom_range(0, 4) != 0)
                len = $urandom_range(k, k + 40);
            else
                len = $urandom_range(1, k);
            if (len > count - pushed)
                len = count - pushed;
            for (int i = 0; i < len; i++) begin
                if (i == 0)
                    flag = !first || ($urandom_range(0, 1) == 1);
                else
                    flag = ($urandom_range(0, 49) == 0);
                queue_sample(pick_sample(), flag);
                pushed++;
            end
            first = 1'b0;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Window of one from reset: every sample is its own maximum.
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h7fff_ffff, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'hffff_ffff, 1'b0);
        queue_sample(32'h7fff_ffff, 1'b1);

        // A zero window length behaves as a window of one.
        write_window(CFG_W'(0));
        queue_sample(32'd5, 1'b0);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'hffff_fffd, 1'b0);

        // Window of three: the maximum leaves the window, and a restart
        // mid-sequence holds results back until three new samples are in.
        write_window(CFG_W'(3));
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h7fff_ffff, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'hffff_ffff, 1'b1);
        queue_sample(32'hffff_fffe, 1'b0);
        queue_sample(32'hffff_fff9, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);

        // Shrinking the window in the middle of a sequence.
        write_window(CFG_W'(2));
        queue_sample(32'd4, 1'b0);
        queue_sample(32'd3, 1'b0);

        random_phase(IDLE_NONE, CFG_W'(64), 130);
        random_phase(IDLE_SRC, CFG_W'(127), 120);
        random_phase(IDLE_SINK, CFG_W'(0), 110);
        random_phase(IDLE_BOTH, CFG_W'(5), 120);
        random_phase(IDLE_SRC, CFG_W'(1), 100);
        random_phase(IDLE_SINK, CFG_W'($urandom_range(2, 63)), 120);
        random_phase(IDLE_BOTH, CFG_W'(64), 130);
        random_phase(IDLE_NONE, CFG_W'($urandom_range(0, 127)), 120);

        drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
